>>> hdl/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// Shared types and codes of the scripted event sequencer.
// ----------------------------------------------------------------------------
package ses_pkg;

	localparam int MaxEventsDef  = 64;
	localparam int NumConditions = 16;
	localparam int MaxBranches   = 4;

	localparam logic [1:0] ACT_STEP    = 2'd0;
	localparam logic [1:0] ACT_APPEND  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [2:0] EV_TIMED  = 3'd0;
	localparam logic [2:0] EV_WAIT   = 3'd1;
	localparam logic [2:0] EV_JUMP   = 3'd2;
	localparam logic [2:0] EV_CJUMP  = 3'd3;
	localparam logic [2:0] EV_TRANS  = 3'd4;
	localparam logic [2:0] EV_MTRANS = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ses_state_t;

	typedef struct packed {
		logic load;
		logic wr;
		logic exec;
	} ses_cmd_t;

	typedef struct packed {
		logic full;
	} ses_sts_t;

endpackage

>>> hdl/scripted_event_sequencer.sv
// ----------------------------------------------------------------------------
// scripted_event_sequencer
// Event program table stepped against a millisecond time and condition bits.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. At the accept edge
// the current event is read from the table (an append that finds the table
// not full writes its event at that edge); the execute cycle updates position,
// time mark and event count. In the cycle after it the result stands on the
// result ports for exactly one cycle with done high; the receiver cannot stall it,
// so sample it then. busy is low while a result is shown, so a new word may
// be started in that cycle.
module scripted_event_sequencer #(
	parameter int MAX_EVENTS = ses_pkg::MaxEventsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic [15:0] cond_flags,
	input  logic [2:0]  ev_type,
	input  logic [31:0] ev_interval,
	input  logic [15:0] ev_conds,
	input  logic [31:0] ev_targets,
	input  logic [2:0]  ev_branches,
	input  logic [7:0]  ev_action_id,
	input  logic [7:0]  ev_message_id,
	output logic        done,
	output logic        fired,
	output logic [7:0]  fired_action,
	output logic [7:0]  fired_message,
	output logic [6:0]  position,
	output logic        finished,
	output logic        rejected
);
	import ses_pkg::*;

	ses_cmd_t cmd;
	ses_sts_t sts;

	ses_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ses_dpath #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.now_ms        (now_ms),
		.cond_flags    (cond_flags),
		.ev_type       (ev_type),
		.ev_interval   (ev_interval),
		.ev_conds      (ev_conds),
		.ev_targets    (ev_targets),
		.ev_branches   (ev_branches),
		.ev_action_id  (ev_action_id),
		.ev_message_id (ev_message_id),
		.fired         (fired),
		.fired_action  (fired_action),
		.fired_message (fired_message),
		.position      (position),
		.finished      (finished),
		.rejected      (rejected)
	);

endmodule

>>> hdl/ses_ctrl.sv
// ----------------------------------------------------------------------------
// ses_ctrl
// Controller: takes a word, runs its execute state, strobes the result.
// ----------------------------------------------------------------------------
module ses_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  ses_pkg::ses_sts_t sts,
	output ses_pkg::ses_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import ses_pkg::*;

	ses_state_t state_q, state_d;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.wr   = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.wr   = (action == ACT_APPEND) && !sts.full;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign done = done_q;

endmodule

>>> hdl/ses_dpath.sv
// ----------------------------------------------------------------------------
// ses_dpath
// Datapath: event tables, program state and result registers.
// ----------------------------------------------------------------------------
module ses_dpath #(
	parameter int MAX_EVENTS = ses_pkg::MaxEventsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ses_pkg::ses_cmd_t cmd,
	output ses_pkg::ses_sts_t sts,
	input  logic [1:0]        action,
	input  logic [31:0]       now_ms,
	input  logic [15:0]       cond_flags,
	input  logic [2:0]        ev_type,
	input  logic [31:0]       ev_interval,
	input  logic [15:0]       ev_conds,
	input  logic [31:0]       ev_targets,
	input  logic [2:0]        ev_branches,
	input  logic [7:0]        ev_action_id,
	input  logic [7:0]        ev_message_id,
	output logic              fired,
	output logic [7:0]        fired_action,
	output logic [7:0]        fired_message,
	output logic [6:0]        position,
	output logic              finished,
	output logic              rejected
);
	import ses_pkg::*;

	localparam int AW = $clog2(MAX_EVENTS);
	localparam int CW = $clog2(MAX_EVENTS + 1);

	logic [50:0] tm_mem [MAX_EVENTS];
	logic [50:0] br_mem [MAX_EVENTS];

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [31:0]   mark_q, mark_d;

	logic [1:0]  act_q;
	logic [31:0] now_q;
	logic [15:0] flags_q;
	logic [50:0] tm_rd_q;
	logic [50:0] br_rd_q;

	logic        fired_q, rej_q, fin_q;
	logic [7:0]  fact_q, fmsg_q;
	logic [CW-1:0] posout_q;

	logic [2:0]  rd_kind;
	logic [31:0] rd_interval;
	logic [7:0]  rd_act;
	logic [7:0]  rd_msg;
	logic [15:0] rd_conds;
	logic [31:0] rd_targets;
	logic [2:0]  rd_branches;
	logic [3:0]  hit;
	logic [7:0]  tgt [4];

	logic        fire_d, rej_d, jmp_en;
	logic [7:0]  jmp_t;
	logic [2:0]  nbr;
	logic        found;
	logic        tgt_ok;

	assign sts.full = (count_q >= CW'(MAX_EVENTS));

	// tables
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			tm_mem[count_q[AW-1:0]] <= {ev_type, ev_interval, ev_action_id, ev_message_id};
			br_mem[count_q[AW-1:0]] <= {ev_conds, ev_targets, ev_branches};
		end
		if (cmd.load) begin
			tm_rd_q <= tm_mem[pos_q[AW-1:0]];
			br_rd_q <= br_mem[pos_q[AW-1:0]];
			act_q   <= action;
			now_q   <= now_ms;
			flags_q <= cond_flags;
		end
	end

	assign {rd_kind, rd_interval, rd_act, rd_msg} = tm_rd_q;
	assign {rd_conds, rd_targets, rd_branches}    = br_rd_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hit[i] = (5'(rd_conds[4*i +: 4]) < 5'(NumConditions))
				&& flags_q[rd_conds[4*i +: 4]];
			tgt[i] = rd_targets[8*i +: 8];
		end
	end

	assign nbr = (rd_branches > 3'(MaxBranches)) ? 3'(MaxBranches) : rd_branches;

	always_comb begin
		count_d = count_q;
		pos_d   = pos_q;
		mark_d  = mark_q;
		fire_d  = 1'b0;
		rej_d   = 1'b0;
		jmp_en  = 1'b0;
		jmp_t   = 8'd0;
		found   = 1'b0;
		unique case (act_q)
			ACT_APPEND: begin
				if (sts.full) rej_d = 1'b1;
				else count_d = count_q + CW'(1);
			end
			ACT_RESTART: begin
				pos_d  = '0;
				mark_d = now_q;
			end
			ACT_STEP: begin
				if (pos_q < count_q) begin
					unique case (rd_kind)
						EV_TIMED: begin
							if ((now_q - mark_q) >= rd_interval) begin
								fire_d = 1'b1;
								mark_d = now_q;
								pos_d  = pos_q + CW'(1);
							end
						end
						EV_WAIT: begin
							if (hit[0]) pos_d = pos_q + CW'(1);
						end
						EV_JUMP: begin
							jmp_en = 1'b1;
							jmp_t  = tgt[0];
						end
						EV_CJUMP: begin
							jmp_en = 1'b1;
							jmp_t  = hit[0] ? tgt[1] : tgt[0];
						end
						EV_TRANS: begin
							jmp_en = hit[0];
							jmp_t  = tgt[0];
						end
						EV_MTRANS: begin
							for (int i = 0; i < 4; i++) begin
								if (!found && (3'(i) < nbr) && hit[i]) begin
									found = 1'b1;
									jmp_t = tgt[i];
								end
							end
							jmp_en = found;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		tgt_ok = (jmp_t != 8'd0) && (jmp_t <= 8'(count_q));
		if (jmp_en && tgt_ok) begin
			pos_d  = CW'(jmp_t - 8'd1);
			mark_d = now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			mark_q  <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
			pos_q   <= pos_d;
			mark_q  <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fired_q  <= fire_d;
			fact_q   <= fire_d ? rd_act : 8'd0;
			fmsg_q   <= fire_d ? rd_msg : 8'd0;
			posout_q <= pos_d;
			fin_q    <= (pos_d >= count_d);
			rej_q    <= rej_d;
		end
	end

	assign fired         = fired_q;
	assign fired_action  = fact_q;
	assign fired_message = fmsg_q;
	assign position      = 7'(posout_q);
	assign finished      = fin_q;
	assign rejected      = rej_q;

endmodule
